### design/three_stream_coincidence_matcher_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the three stream coincidence matcher
// Clocked on clk; the reset-qualified form is disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef THREE_STREAM_COINCIDENCE_MATCHER_DEFINES_SVH
`define THREE_STREAM_COINCIDENCE_MATCHER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check a property outside reset
`define TSCM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// check a property at every edge, reset included
`define TSCM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TSCM_ASSERT(lbl, prop, msg)
`define TSCM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### design/tscm_pkg.sv
// ---------------------------------------------------------------------------
// tscm_pkg
// Shared types and constants of the three stream coincidence matcher.
// ---------------------------------------------------------------------------
package tscm_pkg;

	// Field and bus widths
	localparam int TAG_BITS_DEF  = 48;
	localparam int FIELD_BITS    = 48;
	localparam int NSTREAMS      = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 2;
	localparam int S_TDATA_BITS  = 144;
	localparam int M_TDATA_BITS  = 152;
	localparam int M_USED_BITS   = 148;

	// Register indexes
	localparam logic [CFG_ADDR_BITS-1:0] REG_OFFSET1 = 2'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_OFFSET2 = 2'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW  = 2'd2;

	// Reset values
	localparam logic [CFG_DATA_BITS-1:0] WINDOW_RESET = 32'd1000;
	localparam logic [NSTREAMS-1:0]      MASK_ALL     = 3'b111;

	typedef struct packed {
		logic signed [CFG_DATA_BITS-1:0] offset1;
		logic signed [CFG_DATA_BITS-1:0] offset2;
		logic [CFG_DATA_BITS-1:0]        window;
	} cfg_t;

	typedef struct packed {
		logic                  matched;
		logic [NSTREAMS-1:0]   advance_mask;
		logic [FIELD_BITS-1:0] event_tag0;
		logic [FIELD_BITS-1:0] event_tag1;
		logic [FIELD_BITS-1:0] event_tag2;
	} result_t;

endpackage

### design/tscm_cfg.sv
// ---------------------------------------------------------------------------
// tscm_cfg
// Configuration register file: offsets of streams 1 and 2 and the window.
// ---------------------------------------------------------------------------
module tscm_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tscm_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [tscm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	output tscm_pkg::cfg_t                      cfg
);

	tscm_pkg::cfg_t cfg_q;

	// Write the addressed register; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset1 <= '0;
			cfg_q.offset2 <= '0;
			cfg_q.window  <= tscm_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				tscm_pkg::REG_OFFSET1: cfg_q.offset1 <= cfg_wdata;
				tscm_pkg::REG_OFFSET2: cfg_q.offset2 <= cfg_wdata;
				tscm_pkg::REG_WINDOW:  cfg_q.window  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/tscm_core.sv
// ---------------------------------------------------------------------------
// tscm_core
// Input register, head tag state and the combinational compare-and-advance
// decision that produces one result per input transaction.
// ---------------------------------------------------------------------------
`include "three_stream_coincidence_matcher_defines.svh"

module tscm_core #(
	parameter int TAG_BITS = tscm_pkg::TAG_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tscm_pkg::FIELD_BITS-1:0]   in_tag [tscm_pkg::NSTREAMS],
	input  tscm_pkg::cfg_t                    cfg,
	output logic                              res_valid,
	input  logic                              res_ready,
	output tscm_pkg::result_t                 res
);

	// Wide enough for a tag or a 32-bit offset, plus sign and carry
	localparam int WIDE_BITS = (TAG_BITS > tscm_pkg::CFG_DATA_BITS) ?
		TAG_BITS : tscm_pkg::CFG_DATA_BITS;
	localparam int CORR_BITS = WIDE_BITS + 2;
	localparam int DIFF_BITS = CORR_BITS + 1;
	localparam int NS        = tscm_pkg::NSTREAMS;

	logic                          valid_s1;
	logic [TAG_BITS-1:0]           tag_s1   [NS];
	logic [TAG_BITS-1:0]           tag_in   [NS];
	logic [TAG_BITS-1:0]           head_q   [NS];
	logic [TAG_BITS-1:0]           head_cur [NS];
	logic [tscm_pkg::FIELD_BITS-1:0] head_out [NS];
	logic [NS-1:0]                 need_q;
	logic signed [CORR_BITS-1:0]   corr     [NS];
	logic signed [DIFF_BITS-1:0]   win_ext;
	logic [NS-1:0]                 lag;
	logic                          adv;

	// Resize the 48-bit fields to the tag width and back
	for (genvar i = 0; i < NS; i++) begin : g_resize
		if (TAG_BITS > tscm_pkg::FIELD_BITS) begin : g_wide
			assign tag_in[i]   = {{(TAG_BITS - tscm_pkg::FIELD_BITS){1'b0}}, in_tag[i]};
			assign head_out[i] = head_cur[i][tscm_pkg::FIELD_BITS-1:0];
		end else if (TAG_BITS == tscm_pkg::FIELD_BITS) begin : g_same
			assign tag_in[i]   = in_tag[i];
			assign head_out[i] = head_cur[i];
		end else begin : g_narrow
			assign tag_in[i]   = in_tag[i][TAG_BITS-1:0];
			assign head_out[i] =
				{{(tscm_pkg::FIELD_BITS - TAG_BITS){1'b0}}, head_cur[i]};
		end
	end

	// Advance the input stage whenever the result register can take it
	assign adv       = valid_s1 && res_ready;
	assign in_ready  = !valid_s1 || res_ready;
	assign res_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tag_s1 <= tag_in;
		end
	end

	// Load fresh tags for the requested streams
	always_comb begin
		for (int i = 0; i < NS; i++) begin
			head_cur[i] = need_q[i] ? tag_s1[i] : head_q[i];
		end
	end

	// Corrected times: stream 0 raw, streams 1 and 2 plus signed offsets
	assign corr[0] = signed'({{(CORR_BITS - TAG_BITS){1'b0}}, head_cur[0]});
	assign corr[1] = signed'({{(CORR_BITS - TAG_BITS){1'b0}}, head_cur[1]})
		+ signed'({{(CORR_BITS - 32){cfg.offset1[31]}}, cfg.offset1});
	assign corr[2] = signed'({{(CORR_BITS - TAG_BITS){1'b0}}, head_cur[2]})
		+ signed'({{(CORR_BITS - 32){cfg.offset2[31]}}, cfg.offset2});

	assign win_ext = signed'({{(DIFF_BITS - 32){1'b0}}, cfg.window});

	// A stream lags when any other stream leads it by more than the window;
	// the largest time is the seed, so this matches the distance from the seed
	always_comb begin
		logic signed [DIFF_BITS-1:0] d;
		lag = '0;
		for (int i = 0; i < NS; i++) begin
			for (int j = 0; j < NS; j++) begin
				d = DIFF_BITS'(corr[j]) - DIFF_BITS'(corr[i]);
				if (i != j && d > win_ext) begin
					lag[i] = 1'b1;
				end
			end
		end
	end

	// Build the result
	always_comb begin
		res.matched      = (lag == '0);
		res.advance_mask = (lag == '0) ? tscm_pkg::MASK_ALL : lag;
		res.event_tag0   = (lag == '0) ? head_out[0] : '0;
		res.event_tag1   = (lag == '0) ? head_out[1] : '0;
		res.event_tag2   = (lag == '0) ? head_out[2] : '0;
	end

	// Commit heads and the request mask when the result moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= tscm_pkg::MASK_ALL;
		end else if (adv) begin
			need_q <= res.advance_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			head_q <= head_cur;
		end
	end

	`TSCM_ASSERT_ALWAYS(a_need_nonzero, !arst_n || need_q != '0, "request mask is empty")
	`TSCM_ASSERT(a_need_follows, adv |=> need_q == $past(res.advance_mask),
		"request mask does not follow the delivered result")
	`TSCM_ASSERT(a_miss_not_all, adv && !res.matched |=> need_q != tscm_pkg::MASK_ALL,
		"mismatch requested every stream")
	`TSCM_ASSERT(a_hold_stalled, !adv |=> need_q == $past(need_q),
		"request mask changed without a result")

endmodule

### design/tscm_out.sv
// ---------------------------------------------------------------------------
// tscm_out
// Output register: holds one result for the master stream; while it is full
// and m_tready is low, res_ready is low and the core holds its result.
// ---------------------------------------------------------------------------
module tscm_out (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 res_valid,
	output logic                                 res_ready,
	input  tscm_pkg::result_t                    res,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [tscm_pkg::M_TDATA_BITS-1:0]    m_tdata
);

	logic              valid_q;
	tscm_pkg::result_t res_q;

	assign res_ready = !valid_q || m_tready;

	// Take a new result whenever the slot is empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	// Pack: matched, advance_mask, event_tag0..2, zero fill
	assign m_tvalid = valid_q;
	assign m_tdata  = {
		{(tscm_pkg::M_TDATA_BITS - tscm_pkg::M_USED_BITS){1'b0}},
		res_q.event_tag2, res_q.event_tag1, res_q.event_tag0,
		res_q.advance_mask, res_q.matched
	};

endmodule

### design/three_stream_coincidence_matcher.sv
// ---------------------------------------------------------------------------
// three_stream_coincidence_matcher
// Builds coincident events from the head tags of three timestamp streams.
//
// The slave stream carries one transaction per decision: fresh tags for the
// streams that the previous result asked for (other tag fields are ignored).
// The master stream returns one result per input transaction: matched, the
// advance mask naming the streams that must supply their next tag, and the
// raw head tags of a matched event (zero when there is no match).
// Streams 1 and 2 are shifted by signed offsets before comparison; a match
// needs every corrected time within the window of the largest one.
// Pipeline: two register stages; an accepted transaction is held in the input
// register, then in the output register, which drives m_tvalid.
// Throughput: one transaction per cycle while m_tready is high; the advance mask
// loops from the decision logic through need_q back into the head select.
// Reset: the first transaction loads all three heads, offsets clear and the
// window is 1000 ns. Head tags are not reset.
// Stall: the output register holds its result while m_tready is low; the
// input register takes one more transaction, then s_tready drops.
// Write configuration only while no transaction is in flight.
// ---------------------------------------------------------------------------
module three_stream_coincidence_matcher #(
	parameter int TAG_BITS = tscm_pkg::TAG_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// tag_stream0 [47:0], tag_stream1 [95:48], tag_stream2 [143:96]
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tscm_pkg::S_TDATA_BITS-1:0]   s_tdata,
	// matched [0], advance_mask [3:1], event_tag0 [51:4], event_tag1 [99:52],
	// event_tag2 [147:100], zero [151:148]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tscm_pkg::M_TDATA_BITS-1:0]   m_tdata,
	input  logic                                cfg_we,
	input  logic [tscm_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [tscm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

	localparam int FB = tscm_pkg::FIELD_BITS;

	tscm_pkg::cfg_t    cfg;
	tscm_pkg::result_t res;
	logic              res_valid;
	logic              res_ready;
	logic [FB-1:0]     in_tag [tscm_pkg::NSTREAMS];

	// Unpack the input transaction
	assign in_tag[0] = s_tdata[FB-1:0];
	assign in_tag[1] = s_tdata[2*FB-1:FB];
	assign in_tag[2] = s_tdata[3*FB-1:2*FB];

	tscm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tscm_core #(
		.TAG_BITS (TAG_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_tag    (in_tag),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	tscm_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

### test/coincidence_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coincidence_checker
// Watches the tag, result and register channels of the coincidence matcher.
// Keeps its own copy of the head tags, the advance mask and the registers,
// predicts one event result per accepted tag transaction, and compares each
// accepted result, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module coincidence_checker
	import tscm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [S_TDATA_BITS-1:0]  s_tdata,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [M_TDATA_BITS-1:0]  m_tdata,
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	output int                       errors,
	output int                       pending
);

	cfg_t                  cfg_now;
	logic [FIELD_BITS-1:0] head_tag [NSTREAMS];
	logic [NSTREAMS-1:0]   want_mask;
	result_t               event_q [$];
	result_t               want;
	result_t               got;

	// Sign-extend a 32-bit offset register to a 64-bit time
	function automatic longint widen_offset(input logic [CFG_DATA_BITS-1:0] v);
		return longint'({{32{v[CFG_DATA_BITS-1]}}, v});
	endfunction

	// Load requested heads, find the seed and decide match or advance
	function automatic result_t build_event(input logic [S_TDATA_BITS-1:0] tags);
		longint              corr [NSTREAMS];
		longint              seed;
		logic [NSTREAMS-1:0] lag;
		result_t             r;
		for (int i = 0; i < NSTREAMS; i++) begin
			if (want_mask[i]) begin
				head_tag[i] = tags[i*FIELD_BITS +: FIELD_BITS];
			end
		end
		corr[0] = longint'({16'd0, head_tag[0]});
		corr[1] = longint'({16'd0, head_tag[1]}) + widen_offset(cfg_now.offset1);
		corr[2] = longint'({16'd0, head_tag[2]}) + widen_offset(cfg_now.offset2);
		seed = corr[0];
		for (int i = 1; i < NSTREAMS; i++) begin
			if (corr[i] > seed) begin
				seed = corr[i];
			end
		end
		lag = '0;
		for (int i = 0; i < NSTREAMS; i++) begin
			if (seed - corr[i] > longint'({32'd0, cfg_now.window})) begin
				lag[i] = 1'b1;
			end
		end
		r = '0;
		if (lag == '0) begin
			r.matched      = 1'b1;
			r.advance_mask = MASK_ALL;
			r.event_tag0   = head_tag[0];
			r.event_tag1   = head_tag[1];
			r.event_tag2   = head_tag[2];
			want_mask      = MASK_ALL;
		end else begin
			r.advance_mask = lag;
			want_mask      = lag;
		end
		return r;
	endfunction

	// Track transactions: predict on input, compare on output, follow writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_now.offset1 = '0;
			cfg_now.offset2 = '0;
			cfg_now.window  = WINDOW_RESET;
			want_mask       = MASK_ALL;
			event_q.delete();
			pending         = 0;
			errors          = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				event_q.insert(event_q.size(), build_event(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				got.matched      = m_tdata[0];
				got.advance_mask = m_tdata[3:1];
				got.event_tag0   = m_tdata[51:4];
				got.event_tag1   = m_tdata[99:52];
				got.event_tag2   = m_tdata[147:100];
				if (event_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%t: result with no event pending: %h", $realtime, m_tdata);
					end
				end else begin
					want = event_q.pop_front();
					if (got.matched !== want.matched || got.advance_mask !== want.advance_mask ||
						got.event_tag0 !== want.event_tag0 ||
						got.event_tag1 !== want.event_tag1 ||
						got.event_tag2 !== want.event_tag2) begin
						errors++;
						if (errors <= 10) begin
							$display("%t: event mismatch", $realtime);
							$display("  expected matched=%b mask=%b tags=%h %h %h",
								want.matched, want.advance_mask,
								want.event_tag0, want.event_tag1, want.event_tag2);
							$display("  actual   matched=%b mask=%b tags=%h %h %h",
								got.matched, got.advance_mask,
								got.event_tag0, got.event_tag1, got.event_tag2);
						end
					end
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_OFFSET1: begin
						cfg_now.offset1 = cfg_wdata;
					end
					REG_OFFSET2: begin
						cfg_now.offset2 = cfg_wdata;
					end
					REG_WINDOW: begin
						cfg_now.window = cfg_wdata;
					end
					default: begin
					end
				endcase
			end
			pending = event_q.size();
		end
	end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the three stream coincidence matcher.
// A short directed run covers tag extremes, window edges, tied seeds,
// ignored tag fields and extreme offsets; then five register settings each
// get a run of random tag transactions that mostly track a moving time base
// (so events match often) with some stray tags mixed in. Both sides idle at
// random, and the result side holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb;
	import tscm_pkg::*;

	localparam longint TMAX     = 64'h0000_FFFF_FFFF_FFFF;
	localparam longint HALF     = 64'h0000_0000_8000_0000;
	localparam longint FAR_TIME = 64'h0000_0100_0000_0000;
	localparam int     PER_SET  = 280;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [S_TDATA_BITS-1:0]  s_tdata;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [M_TDATA_BITS-1:0]  m_tdata;
	logic                     cfg_we;
	logic [CFG_ADDR_BITS-1:0] cfg_addr;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;
	int                       errors;
	int                       pending;

	bit                       calm;
	bit                       hold_req;
	longint                   base_time;
	int                       off1;
	int                       off2;
	logic [CFG_DATA_BITS-1:0] window;

	three_stream_coincidence_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	coincidence_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bound the run
	initial begin
		#400_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: random stalls, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (60) @(negedge clk);
			end
			m_tready = calm || ($urandom_range(0, 99) >= 21);
		end
	end

	// Offer one tag transaction and hold it until accepted
	task automatic offer_tags(input longint t0, input longint t1, input longint t2);
		while (!calm && $urandom_range(0, 99) < 21) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {t2[47:0], t1[47:0], t0[47:0]};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_ADDR_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Wait for every event to come back, then let the pipeline settle
	task automatic drain();
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write all registers while idle; jump the time base past stale heads
	task automatic load_settings(input logic [CFG_DATA_BITS-1:0] o1,
			input logic [CFG_DATA_BITS-1:0] o2, input logic [CFG_DATA_BITS-1:0] w);
		drain();
		set_reg(REG_OFFSET1, o1);
		set_reg(REG_OFFSET2, o2);
		set_reg(REG_WINDOW, w);
		off1      = o1;
		off2      = o2;
		window    = w;
		base_time = base_time + 64'h8_0000_0000;
	endtask

	// Tag near the time base, corrected for the stream offset; sometimes stray
	function automatic longint tag_for(input longint shift);
		longint jit;
		if ($urandom_range(0, 5) == 0) begin
			return longint'({$urandom, $urandom} >> 17) % base_time;
		end
		if ($urandom_range(0, 4) == 0) begin
			jit = longint'(window) + 1 + longint'($urandom_range(0, window));
		end else begin
			jit = longint'($urandom_range(0, window));
		end
		return base_time + jit - shift;
	endfunction

	task automatic offer_random();
		longint t0;
		longint t1;
		longint t2;
		base_time = base_time + longint'($urandom_range(0, window))
			+ longint'($urandom_range(0, 2));
		t0 = tag_for(0);
		t1 = tag_for(off1);
		t2 = tag_for(off2);
		offer_tags(t0, t1, t2);
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_addr  = REG_OFFSET1;
		cfg_wdata = '0;
		calm      = 1'b0;
		hold_req  = 1'b0;
		base_time = 64'h0000_1000_0000_0000;
		off1      = 0;
		off2      = 0;
		window    = WINDOW_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: extremes, window edges, tied seed, ignored fields
		offer_tags(0, 0, 0);
		offer_tags(TMAX, TMAX, TMAX);
		offer_tags(0, TMAX, 0);
		offer_tags(TMAX - 1000, 64'h3039, TMAX);
		offer_tags(1000, 0, 0);
		offer_tags(0, 1001, 500);
		offer_tags(1001, TMAX, TMAX);
		offer_tags(5000, 5000, 4000);
		offer_tags(5000, 5000, 3999);
		offer_tags(TMAX, TMAX, 4500);

		// Extreme offsets with a zero window, corrected times going negative
		load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
		offer_tags(FAR_TIME, FAR_TIME + HALF, FAR_TIME - (HALF - 1));
		offer_tags(0, 0, 0);
		offer_tags(HALF - 1, 2 * HALF - 1, 64'hABCD);
		offer_tags(TMAX, TMAX, 0);

		// Widest window: edges at 2^32 - 1 and 2^32
		load_settings(32'd0, 32'd0, 32'hFFFF_FFFF);
		offer_tags(64'h123, TMAX, TMAX - 64'hFFFF_FFFF);
		offer_tags(0, 64'hFFFF_FFFF, 0);
		offer_tags(0, 64'h1_0000_0000, 0);
		offer_tags(64'h1_0000_0000, TMAX, 64'h1_0000_0000);

		// Random tags under several register settings
		for (int set_no = 0; set_no < 5; set_no++) begin
			case (set_no)
				0: begin
					load_settings($urandom, $urandom, WINDOW_RESET);
				end
				1: begin
					load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
				end
				2: begin
					load_settings($urandom, $urandom, $urandom_range(0, 100000));
				end
				3: begin
					load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
				end
				default: begin
					load_settings($urandom, $urandom, $urandom);
				end
			endcase
			for (int n = 0; n < PER_SET; n++) begin
				calm = (set_no == 0) && (n >= 40) && (n < 160);
				if (set_no == 0 && n == 200) begin
					hold_req = 1'b1;
				end
				offer_random();
			end
		end
		calm = 1'b0;

		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
